>>> design/slcc_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and command table of the serial led command controller
package slcc_pkg;

	localparam int BYTE_W      = 8;
	localparam int NUM_LEDS    = 3;
	localparam int NUM_CMDS    = 11;
	localparam int MAX_CMD_LEN = 10;
	localparam int CMD_LEN_W   = $clog2(MAX_CMD_LEN + 1);
	localparam int BUF_IDX_W   = $clog2(MAX_CMD_LEN);
	localparam int PERIOD_W    = 8;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 8;

	// operation codes
	localparam logic [1:0] OP_RX    = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_PRESS = 2'd2;

	// speed message codes
	localparam logic [1:0] SPEED_NONE = 2'd0;
	localparam logic [1:0] SPEED_FAST = 2'd1;
	localparam logic [1:0] SPEED_SLOW = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD = 1'b1;

	localparam logic [PERIOD_W-1:0] FAST_PERIOD_RESET = 8'd1;
	localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RESET = 8'd5;

	localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0d;
	localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0a;

	typedef enum logic [1:0] {
		ACT_ON    = 2'd0,
		ACT_OFF   = 2'd1,
		ACT_BLINK = 2'd2
	} action_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [BYTE_W-1:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [NUM_LEDS-1:0] led_levels;
		logic                echo_valid;
		logic [BYTE_W-1:0]   echo_byte;
		logic                overflow_newline;
		logic                unknown_command;
		logic                prompt;
		logic [1:0]          speed_message;
	} out_item_t;

	// command text is left-justified: character 0 sits in the top byte
	typedef struct packed {
		logic [MAX_CMD_LEN*BYTE_W-1:0] text;
		logic [CMD_LEN_W-1:0]          len;
		logic [NUM_LEDS-1:0]           mask;
		action_t                       action;
	} cmd_entry_t;

	typedef struct packed {
		logic                hit;
		logic [NUM_LEDS-1:0] mask;
		action_t             action;
	} match_t;

	typedef struct packed {
		logic tick;
		logic press;
	} timer_event_t;

	typedef struct packed {
		logic toggle;
		logic slow_next;
	} timer_status_t;

	localparam cmd_entry_t CMD_TABLE [NUM_CMDS] = '{
		'{ {"LED1 ON",    24'h0}, 4'd7,  3'b001, ACT_ON    },
		'{ {"LED1 OFF",   16'h0}, 4'd8,  3'b001, ACT_OFF   },
		'{ {"LED1 BLINK"       }, 4'd10, 3'b001, ACT_BLINK },
		'{ {"LED2 ON",    24'h0}, 4'd7,  3'b010, ACT_ON    },
		'{ {"LED2 OFF",   16'h0}, 4'd8,  3'b010, ACT_OFF   },
		'{ {"LED2 BLINK"       }, 4'd10, 3'b010, ACT_BLINK },
		'{ {"LED3 ON",    24'h0}, 4'd7,  3'b100, ACT_ON    },
		'{ {"LED3 OFF",   16'h0}, 4'd8,  3'b100, ACT_OFF   },
		'{ {"LED3 BLINK"       }, 4'd10, 3'b100, ACT_BLINK },
		'{ {"ALL ON",     32'h0}, 4'd6,  3'b111, ACT_ON    },
		'{ {"ALL OFF",    24'h0}, 4'd7,  3'b111, ACT_OFF   }
	};

endpackage

>>> design/slcc_cmd_match.sv
`timescale 1ns / 1ps
// exact match of the buffered line against the command table
module slcc_cmd_match #(
	parameter int LEN_W = 6
) (
	input  logic [slcc_pkg::MAX_CMD_LEN-1:0][slcc_pkg::BYTE_W-1:0] line_bytes,
	input  logic [LEN_W-1:0]                                        line_len,
	output slcc_pkg::match_t                                        match
);

	logic [slcc_pkg::NUM_CMDS-1:0] hit_vec;

	always_comb begin
		for (int k = 0; k < slcc_pkg::NUM_CMDS; k++) begin
			hit_vec[k] = (line_len == LEN_W'(slcc_pkg::CMD_TABLE[k].len));
			for (int i = 0; i < slcc_pkg::MAX_CMD_LEN; i++) begin
				if (i < int'(slcc_pkg::CMD_TABLE[k].len) &&
				    line_bytes[i] != slcc_pkg::CMD_TABLE[k].text[
				        (slcc_pkg::MAX_CMD_LEN - 1 - i) * slcc_pkg::BYTE_W +: slcc_pkg::BYTE_W]) begin
					hit_vec[k] = 1'b0;
				end
			end
		end
	end

	// commands are distinct, first hit wins
	always_comb begin
		match = '{hit: 1'b0, mask: '0, action: slcc_pkg::ACT_ON};
		for (int k = slcc_pkg::NUM_CMDS - 1; k >= 0; k--) begin
			if (hit_vec[k]) begin
				match.hit    = 1'b1;
				match.mask   = slcc_pkg::CMD_TABLE[k].mask;
				match.action = slcc_pkg::CMD_TABLE[k].action;
			end
		end
	end

endmodule

>>> design/slcc_blink_timer.sv
`timescale 1ns / 1ps
// blink tick counter and fast/slow speed select
module slcc_blink_timer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [slcc_pkg::PERIOD_W-1:0]     fast_period,
	input  logic [slcc_pkg::PERIOD_W-1:0]     slow_period,
	input  slcc_pkg::timer_event_t            ev,
	output slcc_pkg::timer_status_t           status
);

	logic [slcc_pkg::PERIOD_W-1:0] tick_count_q;
	logic                          slow_q;
	logic [slcc_pkg::PERIOD_W-1:0] period;

	assign period           = slow_q ? slow_period : fast_period;
	// also fires when a lowered period left the count above it
	assign status.toggle    = (tick_count_q >= period);
	assign status.slow_next = ~slow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
			slow_q       <= 1'b0;
		end else if (ev.press) begin
			tick_count_q <= '0;
			slow_q       <= ~slow_q;
		end else if (ev.tick) begin
			if (status.toggle) begin
				tick_count_q <= '0;
			end else begin
				tick_count_q <= tick_count_q + 1'b1;
			end
		end
	end

endmodule

>>> design/serial_led_command_controller_unit.sv
`timescale 1ns / 1ps
// top level of the serial led command controller
//
// each input transaction is one event: a received byte, a blink timer tick or
// a speed button press, and each produces exactly one output transaction that
// carries the led levels after the event together with the echo, overflow,
// unknown command, prompt and speed message flags. the block takes one
// transaction per clock cycle for as long as the output side keeps taking
// results; a transaction goes through an input register and a result
// register, and the result register drives the output. a line ends on cr
// or lf and is matched exactly against the eleven commands (LEDn ON,
// LEDn OFF, LEDn BLINK, ALL ON, ALL OFF); anything else, an empty line
// included, reports unknown. a byte arriving with LINE_CAPACITY bytes
// buffered is echoed but dropped, and the line is aborted with a forced
// newline. blinking leds toggle every period+1 ticks; the button swaps fast
// and slow period and drops any partial line. the two period registers are
// written through cfg_we / cfg_index / cfg_wdata; the user must write them
// only while the block is idle, the block itself does not enforce it
module serial_led_command_controller_unit #(
	parameter int LINE_CAPACITY = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  slcc_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output slcc_pkg::out_item_t                out_data,
	input  logic                               cfg_we,
	input  logic [slcc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [slcc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	localparam int LEN_W = $clog2(LINE_CAPACITY + 1);

	// configuration registers
	logic [slcc_pkg::PERIOD_W-1:0] fast_period_q;
	logic [slcc_pkg::PERIOD_W-1:0] slow_period_q;

	// input stage
	logic               valid_s1;
	slcc_pkg::in_item_t item_s1;
	logic               advance;

	// block state
	logic [LEN_W-1:0]                   line_len_q;
	logic [slcc_pkg::NUM_LEDS-1:0]      led_q;
	logic [slcc_pkg::NUM_LEDS-1:0]      blink_q;
	// only the first command-length bytes can ever decide a match
	logic [slcc_pkg::MAX_CMD_LEN-1:0][slcc_pkg::BYTE_W-1:0] line_buf_q;

	// result stage
	logic                valid_s2;
	slcc_pkg::out_item_t result_s2;

	// next-state logic
	slcc_pkg::match_t              match;
	slcc_pkg::timer_event_t        timer_ev;
	slcc_pkg::timer_status_t       timer_st;
	logic                          is_rx;
	logic                          is_eol;
	logic                          line_full;
	logic                          buf_write;
	logic [LEN_W-1:0]              line_len_next;
	logic [slcc_pkg::NUM_LEDS-1:0] led_next;
	logic [slcc_pkg::NUM_LEDS-1:0] blink_next;
	slcc_pkg::out_item_t           result_next;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_period_q <= slcc_pkg::FAST_PERIOD_RESET;
			slow_period_q <= slcc_pkg::SLOW_PERIOD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				slcc_pkg::CFG_FAST_PERIOD: fast_period_q <= cfg_wdata;
				slcc_pkg::CFG_SLOW_PERIOD: slow_period_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ handshake
	// the stage 1 transaction moves on when the result register is free or its result is taken
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// --------------------------------------------------------- line matcher
	slcc_cmd_match #(
		.LEN_W (LEN_W)
	) u_match (
		.line_bytes (line_buf_q),
		.line_len   (line_len_q),
		.match      (match)
	);

	// ----------------------------------------------------------- blink timer
	assign timer_ev.tick  = advance && (item_s1.operation == slcc_pkg::OP_TICK);
	assign timer_ev.press = advance && (item_s1.operation == slcc_pkg::OP_PRESS);

	slcc_blink_timer u_timer (
		.clk         (clk),
		.arst_n      (arst_n),
		.fast_period (fast_period_q),
		.slow_period (slow_period_q),
		.ev          (timer_ev),
		.status      (timer_st)
	);

	// ------------------------------------------------------ event processing
	assign is_rx     = (item_s1.operation == slcc_pkg::OP_RX);
	assign is_eol    = (item_s1.rx_byte == slcc_pkg::CHAR_CR) ||
	                   (item_s1.rx_byte == slcc_pkg::CHAR_LF);
	assign line_full = (line_len_q >= LEN_W'(LINE_CAPACITY));

	always_comb begin
		line_len_next = line_len_q;
		led_next      = led_q;
		blink_next    = blink_q;
		buf_write     = 1'b0;
		result_next   = '0;

		case (item_s1.operation)
			slcc_pkg::OP_RX: begin
				result_next.echo_valid = 1'b1;
				result_next.echo_byte  = item_s1.rx_byte;
				if (line_full) begin
					// overflow: byte dropped, line aborted with a newline
					result_next.overflow_newline = 1'b1;
					result_next.unknown_command  = 1'b1;
					result_next.prompt           = 1'b1;
					line_len_next                = '0;
				end else if (is_eol) begin
					result_next.prompt          = 1'b1;
					result_next.unknown_command = !match.hit;
					line_len_next               = '0;
					if (match.hit) begin
						case (match.action)
							slcc_pkg::ACT_ON: begin
								led_next   = led_q | match.mask;
								blink_next = blink_q & ~match.mask;
							end
							slcc_pkg::ACT_OFF: begin
								led_next   = led_q & ~match.mask;
								blink_next = blink_q & ~match.mask;
							end
							slcc_pkg::ACT_BLINK: begin
								blink_next = blink_q | match.mask;
							end
							default: ;
						endcase
					end
				end else begin
					buf_write     = (line_len_q < LEN_W'(slcc_pkg::MAX_CMD_LEN));
					line_len_next = line_len_q + 1'b1;
				end
			end
			slcc_pkg::OP_TICK: begin
				if (timer_st.toggle) begin
					led_next = led_q ^ blink_q;
				end
			end
			slcc_pkg::OP_PRESS: begin
				// partial line dropped, timer side flips the speed
				line_len_next             = '0;
				result_next.speed_message = timer_st.slow_next ? slcc_pkg::SPEED_SLOW
				                                               : slcc_pkg::SPEED_FAST;
			end
			default: ;
		endcase

		result_next.led_levels = led_next;
	end

	// ----------------------------------------------------------- state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q <= '0;
			led_q      <= '0;
			blink_q    <= '0;
		end else if (advance) begin
			line_len_q <= line_len_next;
			led_q      <= led_next;
			blink_q    <= blink_next;
		end
	end

	// line bytes hold no reset, only entries below the length are compared
	always_ff @(posedge clk) begin
		if (advance && is_rx && buf_write) begin
			line_buf_q[line_len_q[slcc_pkg::BUF_IDX_W-1:0]] <= item_s1.rx_byte;
		end
	end

	// --------------------------------------------------------- result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	// ------------------------------------------------------------ assertions
`ifndef SYNTHESIS
	a_len_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		line_len_q <= LEN_W'(LINE_CAPACITY))
		else $error("line length beyond capacity");

	a_press_clears_line: assert property (@(posedge clk) disable iff (!arst_n)
		timer_ev.press |=> (line_len_q == '0))
		else $error("button press left a partial line");

	a_overflow_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.overflow_newline) |->
		(result_s2.unknown_command && result_s2.prompt && result_s2.echo_valid))
		else $error("overflow result without unknown, prompt and echo");

	a_echo_no_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.echo_valid) |->
		(result_s2.speed_message == slcc_pkg::SPEED_NONE))
		else $error("echo and speed message in one result");
`endif

endmodule
